@@ rtl/lqpa_pkg.sv @@
// Package for the link quality power adapter: payload layouts, event codes, reset values.
`timescale 1ns / 1ps
`default_nettype none
package lqpa_pkg;

   localparam int POWER_MAX     = 3;
   localparam int POWER_W       = $clog2(POWER_MAX + 1);
   localparam int POWER_DEFAULT = (2 > POWER_MAX) ? POWER_MAX : 2;

   localparam logic [31:0] PERIOD_RESET = 32'd100000;
   localparam logic [15:0] MARGIN_RESET = 16'd8;
   localparam logic [15:0] THRESH_RESET = 16'd20;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 56;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_GOOD_RX = 2'd1,
      OP_BAD_RX  = 2'd2,
      OP_BAD_TX  = 2'd3
   } op_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_EVAL_PERIOD = 2'd0,
      CSR_WARN_MARGIN = 2'd1,
      CSR_QUIET_GOOD  = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_addr_type;

   // Request payload, last field in the lowest bits.
   typedef struct packed {
      logic [5:0]  pad;
      logic [31:0] now_us;
      op_type      op;
   } req_data_type;

   // Result payload, last field in the lowest bits.
   typedef struct packed {
      logic [2:0]  pad;
      logic [15:0] tx_bad_seen;
      logic [15:0] rx_bad_seen;
      logic [15:0] good_seen;
      logic        window_closed;
      logic        quality_warning;
      logic        power_changed;
      logic [1:0]  power_out;
   } rsp_data_type;

endpackage
`default_nettype wire

@@ rtl/link_quality_power_adapter_top.sv @@
// Top level of the link quality power adapter: event counters, window evaluation, power control.
//
// Usage: events arrive on the req_ stream (tdata: op, now_us). Good receive, bad receive and
// failed transmit events bump 16-bit wrapping counters; a tick whose time has reached the
// window deadline closes the window, may step the power level up or down and clears the
// counters. Every event yields exactly one result transaction on the rsp_ stream.
// Path: a request is held in the input register, then in the result register that the
// evaluation logic feeds, which drives rsp_tvalid.
// Throughput: one event per cycle while rsp_tready is high; the per-event update of counters,
// deadline and power level is a single pass of logic between the input register and the
// result register.
// Backpressure: when rsp_tready is low the result holds, one more event may wait in the
// input register, and req_tready drops only when both are full.
// Reset (synchronous, active high): counters clear, deadline = 100000, power = 2,
// registers return to period 100000, margin 8, threshold 20; both streams empty.
// csr_ writes take effect at once; the user makes them only while the block is idle (unchecked).
`timescale 1ns / 1ps
`default_nettype none
module link_quality_power_adapter_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // fields from bit 0: op[1:0], now_us[33:2], zero pad
   input  wire logic [lqpa_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // fields from bit 0: power_out[1:0], power_changed[2], quality_warning[3],
   // window_closed[4], good_seen[20:5], rx_bad_seen[36:21], tx_bad_seen[52:37], zero pad
   output logic [lqpa_pkg::RSP_TDATA_W-1:0]         rsp_tdata,
   input  wire logic                                csr_we,
   input  wire logic [lqpa_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [lqpa_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import lqpa_pkg::*;

   // configuration
   logic [31:0]        period_ff;
   logic [15:0]        margin_ff;
   logic [15:0]        thresh_ff;

   // input register
   logic               s1_valid_ff, s1_valid_in;
   req_data_type       s1_data_ff;
   logic               s1_adv;

   // window state
   logic [15:0]        good_ff, good_in;
   logic [15:0]        rx_bad_ff, rx_bad_in;
   logic [15:0]        tx_bad_ff, tx_bad_in;
   logic [31:0]        deadline_ff, deadline_in;
   logic [POWER_W-1:0] power_ff, power_in;

   // result register
   logic               out_valid_ff, out_valid_in;
   rsp_data_type       out_data_ff, out_data_in;

   logic [31:0]        diff;
   logic               closing;
   logic [15:0]        score;
   logic [15:0]        limit;
   logic               changed;
   logic               warn;

   assign s1_adv     = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;

   assign s1_valid_in  = (req_tvalid && req_tready) || (s1_valid_ff && !s1_adv);
   assign out_valid_in = s1_adv || (out_valid_ff && !rsp_tready);

   assign diff    = s1_data_ff.now_us - deadline_ff;
   assign closing = !diff[31];
   assign score   = rx_bad_ff + {tx_bad_ff[14:0], 1'b0};
   assign limit   = good_ff + margin_ff;

   always_comb begin
      good_in     = good_ff;
      rx_bad_in   = rx_bad_ff;
      tx_bad_in   = tx_bad_ff;
      deadline_in = deadline_ff;
      power_in    = power_ff;
      changed     = 1'b0;
      warn        = 1'b0;
      unique case (s1_data_ff.op)
         OP_GOOD_RX: good_in   = good_ff + 16'd1;
         OP_BAD_RX:  rx_bad_in = rx_bad_ff + 16'd1;
         OP_BAD_TX:  tx_bad_in = tx_bad_ff + 16'd1;
         OP_TICK: begin
            if (closing) begin
               deadline_in = s1_data_ff.now_us + period_ff;
               if (score > limit) begin
                  warn = 1'b1;
                  if (power_ff < POWER_W'(POWER_MAX)) begin
                     power_in = power_ff + POWER_W'(1);
                     changed  = 1'b1;
                  end
               end else if (score == 16'd0 && good_ff > thresh_ff &&
                            power_ff != POWER_W'(0)) begin
                  power_in = power_ff - POWER_W'(1);
                  changed  = 1'b1;
               end
               good_in   = 16'd0;
               rx_bad_in = 16'd0;
               tx_bad_in = 16'd0;
            end
         end
         default: ;
      endcase

      out_data_in                 = '0;
      out_data_in.power_out       = 2'(power_in);
      out_data_in.power_changed   = changed;
      out_data_in.quality_warning = warn;
      out_data_in.window_closed   = (s1_data_ff.op == OP_TICK) && closing;
      out_data_in.good_seen       = good_in;
      out_data_in.rx_bad_seen     = rx_bad_in;
      out_data_in.tx_bad_seen     = tx_bad_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         margin_ff <= MARGIN_RESET;
         thresh_ff <= THRESH_RESET;
      end else if (csr_we) begin
         unique case (csr_addr_type'(csr_addr))
            CSR_EVAL_PERIOD: period_ff <= csr_wdata;
            CSR_WARN_MARGIN: margin_ff <= csr_wdata[15:0];
            CSR_QUIET_GOOD:  thresh_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         good_ff      <= '0;
         rx_bad_ff    <= '0;
         tx_bad_ff    <= '0;
         deadline_ff  <= PERIOD_RESET;
         power_ff     <= POWER_W'(POWER_DEFAULT);
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         // advance window state only when the transaction moves to the result register
         if (s1_adv) begin
            good_ff     <= good_in;
            rx_bad_ff   <= rx_bad_in;
            tx_bad_ff   <= tx_bad_in;
            deadline_ff <= deadline_in;
            power_ff    <= power_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_data_ff <= req_data_type'(req_tdata);
      end
      if (s1_adv) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(out_data_ff);

   // A result without a closed window never carries power or warning flags.
   a_flags_need_close: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !out_data_ff.window_closed) |->
         (!out_data_ff.power_changed && !out_data_ff.quality_warning))
      else $error("power flags without window close");

   // A closed window reports cleared counters.
   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_data_ff.window_closed) |->
         (out_data_ff.good_seen == 16'd0 && out_data_ff.rx_bad_seen == 16'd0 &&
          out_data_ff.tx_bad_seen == 16'd0))
      else $error("counters not cleared on window close");

   // With the result register empty the input side must accept.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   // A power step after a warning is always upward.
   a_warn_raises: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && warn && changed) |=> (power_ff == $past(power_ff) + POWER_W'(1)))
      else $error("warning did not raise power");

endmodule
`default_nettype wire
